// ===== hdl/pgig_pkg.sv =====
// Shared types, constants and helpers for the periodic ghost image generator.
// No dependencies; imported by pgig_axis and the top level.
package pgig_pkg;

  localparam int IDX_W   = 16;
  localparam int POS_W   = 32;
  localparam int CUT_W   = 31;
  localparam int NUM_W   = 19;
  localparam int NAXES   = 3;
  localparam int NSUB    = 7;
  localparam int CFG_IDX_W = 8;

  // Largest atom index accepted is MAX_ATOMS - 1.
  localparam logic [31:0] MAX_ATOMS = 32'd65536;

  // Emission order of the axis subsets: x, y, z, xy, xz, yz, xyz.
  localparam logic [NAXES-1:0] SUBSET_ORDER [NSUB] = '{
    3'b001, 3'b010, 3'b100, 3'b011, 3'b101, 3'b110, 3'b111
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LOW_X  = 8'd0,
    REG_BOX_LOW_Y  = 8'd1,
    REG_BOX_LOW_Z  = 8'd2,
    REG_BOX_HIGH_X = 8'd3,
    REG_BOX_HIGH_Y = 8'd4,
    REG_BOX_HIGH_Z = 8'd5,
    REG_CUTOFF     = 8'd6,
    REG_PER_MASK   = 8'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                    flagged;
    logic signed [POS_W-1:0] shifted;
  } axis_res_t;

  // Clamp a 34-bit signed sum into the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [POS_W+1:0] v);
    logic signed [POS_W+1:0] max_v;
    logic signed [POS_W+1:0] min_v;
    max_v = 34'sh0_7FFF_FFFF;
    min_v = -34'sh0_8000_0000;
    if (v > max_v) begin
      return 32'sh7FFF_FFFF;
    end else if (v < min_v) begin
      return 32'sh8000_0000;
    end else begin
      return v[POS_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/periodic_ghost_image_generator.sv =====
// Periodic ghost image generator: one atom in, up to seven ghost images out.
// An atom passes the input register (stage A) and the emit stage (stage B); its ghosts then go to the output register.
// Throughput: one atom per cycle while atoms emit nothing; an atom with ghosts
// holds the emit stage until all of its 1, 3 or 7 ghosts have been emitted.
// Reset (rst_n low, synchronous): all config registers, valids and the ghost
// counter clear to zero; no clearing pass.
module periodic_ghost_image_generator
  import pgig_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [111:0]         in_tdata,   // atom_index[15:0], pos_x, pos_y, pos_z
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [135:0]         out_tdata,  // source_index[15:0], ghost_x, ghost_y,
                                           // ghost_z, shifted_axes[2:0],
                                           // ghost_number[18:0], 2 zero pad bits
  output logic                 out_tlast,  // last ghost of this atom
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic signed [POS_W-1:0] box_low_r  [NAXES];
  logic signed [POS_W-1:0] box_high_r [NAXES];
  logic        [CUT_W-1:0] cutoff_r;
  logic        [NAXES-1:0] per_mask_r;
  logic signed [POS_W:0]   span_r     [NAXES];   // box length per axis, exact

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NAXES; a++) begin
        box_low_r[a]  <= '0;
        box_high_r[a] <= '0;
      end
      cutoff_r   <= '0;
      per_mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_LOW_X:  box_low_r[0]  <= cfg_data;
        REG_BOX_LOW_Y:  box_low_r[1]  <= cfg_data;
        REG_BOX_LOW_Z:  box_low_r[2]  <= cfg_data;
        REG_BOX_HIGH_X: box_high_r[0] <= cfg_data;
        REG_BOX_HIGH_Y: box_high_r[1] <= cfg_data;
        REG_BOX_HIGH_Z: box_high_r[2] <= cfg_data;
        REG_CUTOFF:     cutoff_r      <= cfg_data[CUT_W-1:0];
        REG_PER_MASK:   per_mask_r    <= cfg_data[NAXES-1:0];
        default: ;  // unknown index: write ignored
      endcase
    end
  end

  // Box length is recomputed every cycle; config must only change while idle (the user is bound, the block
  // does not enforce it), so it has settled before the next atom reaches the compute stage.
  always_ff @(posedge clk) begin
    for (int a = 0; a < NAXES; a++) begin
      span_r[a] <= {box_high_r[a][POS_W-1], box_high_r[a]}
                 - {box_low_r[a][POS_W-1], box_low_r[a]};
    end
  end

  // ---------------------------------------------------------------
  // Stage A: input register
  // ---------------------------------------------------------------
  logic                    a_valid_r;
  logic [IDX_W-1:0]        a_idx_r;
  logic signed [POS_W-1:0] a_pos_r [NAXES];
  logic                    a_move;
  logic                    in_xfer;

  assign in_xfer = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_idx_r    <= in_tdata[15:0];
      a_pos_r[0] <= in_tdata[47:16];
      a_pos_r[1] <= in_tdata[79:48];
      a_pos_r[2] <= in_tdata[111:80];
    end
  end

  // Face tests and shifted positions, one unit per axis
  axis_res_t        axis_res [NAXES];
  logic [NAXES-1:0] flags;
  logic [NSUB-1:0]  pend_init;
  logic             idx_ok;

  for (genvar g = 0; g < NAXES; g++) begin : g_axis
    pgig_axis u_axis (
      .en   (per_mask_r[g]),
      .pos  (a_pos_r[g]),
      .lo   (box_low_r[g]),
      .hi   (box_high_r[g]),
      .span (span_r[g]),
      .rc   (cutoff_r),
      .res  (axis_res[g])
    );
    assign flags[g] = axis_res[g].flagged;
  end

  assign idx_ok = ({16'b0, a_idx_r} < MAX_ATOMS);

  // One pending bit per subset, in emission order; all zero drops the atom.
  always_comb begin
    for (int k = 0; k < NSUB; k++) begin
      pend_init[k] = idx_ok && ((SUBSET_ORDER[k] & ~flags) == '0);
    end
  end

  // ---------------------------------------------------------------
  // Stage B: emit stage, one ghost per cycle while the output register can take it, from the held atom
  // ---------------------------------------------------------------
  logic [NSUB-1:0]         b_pend_r;
  logic [IDX_W-1:0]        b_idx_r;
  logic signed [POS_W-1:0] b_pos_r [NAXES];
  logic signed [POS_W-1:0] b_sh_r  [NAXES];

  logic [NSUB-1:0]         sel;
  logic [NAXES-1:0]        emit_axes;
  logic                    emit_last;
  logic                    b_busy;
  logic                    b_ready;
  logic                    out_load;

  assign b_busy    = |b_pend_r;
  assign sel       = b_pend_r & (~b_pend_r + 1'b1);   // lowest pending subset
  assign emit_last = ((b_pend_r & ~sel) == '0);

  always_comb begin
    emit_axes = '0;
    for (int k = 0; k < NSUB; k++) begin
      if (sel[k]) begin
        emit_axes = emit_axes | SUBSET_ORDER[k];
      end
    end
  end

  assign out_load  = b_busy & (~out_tvalid | out_tready);
  assign b_ready   = ~b_busy | (out_load & emit_last);
  assign a_move    = a_valid_r & b_ready;
  assign in_tready = ~a_valid_r | a_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_pend_r <= '0;
    end else if (a_move) begin
      b_pend_r <= pend_init;
    end else if (out_load) begin
      b_pend_r <= b_pend_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_idx_r <= a_idx_r;
      for (int a = 0; a < NAXES; a++) begin
        b_pos_r[a] <= a_pos_r[a];
        b_sh_r[a]  <= axis_res[a].shifted;
      end
    end
  end

  // ---------------------------------------------------------------
  // Output register and ghost counter
  // ---------------------------------------------------------------
  logic                    out_valid_r;
  logic [NUM_W-1:0]        ghost_cnt_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [POS_W-1:0] out_pos_r [NAXES];
  logic [NAXES-1:0]        out_axes_r;
  logic [NUM_W-1:0]        out_num_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ghost_cnt_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        ghost_cnt_r <= ghost_cnt_r + 1'b1;   // wraps at 2^19
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= b_idx_r;
      for (int a = 0; a < NAXES; a++) begin
        out_pos_r[a] <= emit_axes[a] ? b_sh_r[a] : b_pos_r[a];
      end
      out_axes_r <= emit_axes;
      out_num_r  <= ghost_cnt_r;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_num_r, out_axes_r,
                       out_pos_r[2], out_pos_r[1], out_pos_r[0], out_idx_r};

endmodule

// ===== hdl/pgig_axis.sv =====
// Per-axis face test and shifted coordinate for one atom.
// Depends on pgig_pkg (axis_res_t, sat32).
module pgig_axis
  import pgig_pkg::*;
(
  input  logic                    en,
  input  logic signed [POS_W-1:0] pos,
  input  logic signed [POS_W-1:0] lo,
  input  logic signed [POS_W-1:0] hi,
  input  logic signed [POS_W:0]   span,   // hi - lo, exact
  input  logic        [CUT_W-1:0] rc,
  output axis_res_t               res
);

  logic signed [POS_W:0]   d_lo;
  logic signed [POS_W:0]   d_hi;
  logic signed [POS_W:0]   rc_ext;
  logic signed [POS_W+1:0] sum_p;
  logic signed [POS_W+1:0] sum_m;
  logic                    low_hit;
  logic                    high_hit;

  assign d_lo   = {pos[POS_W-1], pos} - {lo[POS_W-1], lo};
  assign d_hi   = {hi[POS_W-1], hi} - {pos[POS_W-1], pos};
  assign rc_ext = {2'b00, rc};

  assign low_hit  = (d_lo <= rc_ext);
  assign high_hit = (d_hi < rc_ext);

  assign sum_p = {{2{pos[POS_W-1]}}, pos} + {span[POS_W], span};
  assign sum_m = {{2{pos[POS_W-1]}}, pos} - {span[POS_W], span};

  always_comb begin
    res.flagged = en & (low_hit | high_hit);
    if (!en) begin
      res.shifted = pos;
    end else if (low_hit) begin
      res.shifted = sat32(sum_p);
    end else if (high_hit) begin
      res.shifted = sat32(sum_m);
    end else begin
      res.shifted = pos;
    end
  end

endmodule
